### src/sdc_pkg.sv
// sdc_pkg: shared types and constants for the sun daypart classifier
// no dependencies; used by every module in src but sdc_ram

package sdc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_DAWN_LEAD     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DAWN_TAIL     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUSK_LEAD     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUSK_TAIL     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TWILIGHT_TAIL = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SUMMER_SHIFT  = 3'd5;

	localparam logic [2:0] PHASE_DAWN     = 3'd0;
	localparam logic [2:0] PHASE_DAY      = 3'd1;
	localparam logic [2:0] PHASE_DUSK     = 3'd2;
	localparam logic [2:0] PHASE_TWILIGHT = 3'd3;
	localparam logic [2:0] PHASE_NIGHT    = 3'd4;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// weekday sum offsets: month key plus day, march 8 and november 1
	localparam logic [12:0] WK_MAR_OFS = 13'd10;
	localparam logic [12:0] WK_NOV_OFS = 13'd3;

	// reciprocal multipliers, exact over the input ranges used
	localparam logic [13:0] RECIP_25 = 14'd2622;
	localparam logic [13:0] RECIP_7  = 14'd9363;

	localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;

	localparam int TIME_W = 11;

	typedef struct packed {
		logic [7:0] dawn_lead;
		logic [7:0] dawn_tail;
		logic [7:0] dusk_lead;
		logic [7:0] dusk_tail;
		logic [7:0] twilight_tail;
		logic [6:0] summer_shift;
	} cfg_t;

	typedef struct packed {
		logic [8:0]  day_idx;
		logic [12:0] wk_sum;
		logic [9:0]  wk_quot;
	} cal_t;

	function automatic logic [8:0] month_start(input logic [3:0] mo);
		logic [8:0] r;
		case (mo)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

### src/sdc_ram.sv
// sdc_ram: generic single write port, single read port ram with registered read
// no dependencies

module sdc_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 366
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/sdc_calendar.sv
// sdc_calendar: day of year and weekday sum for a date, second pipeline stage
// depends on sdc_pkg; quotient by 25 comes in registered from the first stage

module sdc_calendar (
	input  logic [11:0]     year_number,
	input  logic [3:0]      month_number,
	input  logic [4:0]      day_number,
	input  logic [7:0]      year_q25,
	output sdc_pkg::cal_t   cal
);

	logic [11:0] r25;
	logic        div25;
	logic        leap;
	logic [3:0]  mo_c;
	logic [4:0]  dy_c;
	logic [8:0]  doy;
	logic [12:0] yr_sum;
	logic [12:0] wk_sum;
	logic [26:0] wk_prod;

	assign r25   = year_number - 12'(13'(year_q25) * 13'd25);
	assign div25 = (r25 == 12'd0);
	assign leap  = ((year_number[1:0] == 2'd0) && !div25) ||
		((year_number[3:0] == 4'd0) && div25);

	assign mo_c = (month_number < sdc_pkg::MONTH_JAN) ? sdc_pkg::MONTH_JAN :
		(month_number > sdc_pkg::MONTH_DEC) ? sdc_pkg::MONTH_DEC : month_number;
	assign dy_c = (day_number == 5'd0) ? 5'd1 : day_number;

	assign doy = sdc_pkg::month_start(mo_c) + 9'(dy_c) +
		9'(leap && (mo_c > sdc_pkg::MONTH_FEB));

	assign yr_sum = 13'(year_number) + 13'(year_number[11:2]) - 13'(year_q25[7:2]) +
		13'(year_q25[7:4]);
	assign wk_sum = yr_sum + ((month_number == sdc_pkg::MONTH_MAR) ?
		sdc_pkg::WK_MAR_OFS : sdc_pkg::WK_NOV_OFS);
	assign wk_prod = 27'(wk_sum) * 27'(sdc_pkg::RECIP_7);

	assign cal.day_idx = doy - 9'd1;
	assign cal.wk_sum  = wk_sum;
	assign cal.wk_quot = wk_prod[25:16];

endmodule

### src/sdc_phase.sv
// sdc_phase: daylight saving decision and sky phase window compare, third stage
// depends on sdc_pkg; sunrise and sunset arrive from the table rams

module sdc_phase (
	input  sdc_pkg::cfg_t                cfg,
	input  logic [3:0]                   month_number,
	input  logic [4:0]                   day_number,
	input  logic signed [11:0]           minute_of_day,
	input  logic [12:0]                  wk_sum,
	input  logic [9:0]                   wk_quot,
	input  logic [sdc_pkg::TIME_W-1:0]   rise,
	input  logic [sdc_pkg::TIME_W-1:0]   fall,
	output logic [2:0]                   sky_phase,
	output logic                         summer_active
);

	logic [2:0]         wday;
	logic [2:0]         to_sun;
	logic               summer;
	logic [6:0]         shift;
	logic signed [12:0] m;
	logic signed [12:0] rs;
	logic signed [12:0] ss;
	logic signed [12:0] dawn_on;
	logic signed [12:0] day_on;
	logic signed [12:0] dusk_on;
	logic signed [12:0] twi_on;
	logic signed [12:0] night_on;

	assign wday   = 3'(wk_sum - 13'(wk_quot) * 13'd7);
	assign to_sun = (wday == 3'd0) ? 3'd0 : 3'd7 - wday;

	always_comb begin
		if (month_number < sdc_pkg::MONTH_MAR || month_number > sdc_pkg::MONTH_NOV) begin
			summer = 1'b0;
		end else if (month_number == sdc_pkg::MONTH_MAR) begin
			summer = (day_number >= 5'd8 + 5'(to_sun));
		end else if (month_number == sdc_pkg::MONTH_NOV) begin
			summer = (day_number < 5'd1 + 5'(to_sun));
		end else begin
			summer = 1'b1;
		end
	end

	assign shift = summer ? cfg.summer_shift : 7'd0;
	assign m     = 13'(minute_of_day);
	assign rs    = $signed(13'(rise) + 13'(shift));
	assign ss    = $signed(13'(fall) + 13'(shift));

	assign dawn_on  = rs - $signed(13'(cfg.dawn_lead));
	assign day_on   = rs + $signed(13'(cfg.dawn_tail));
	assign dusk_on  = ss - $signed(13'(cfg.dusk_lead));
	assign twi_on   = ss + $signed(13'(cfg.dusk_tail));
	assign night_on = ss + $signed(13'(cfg.twilight_tail));

	always_comb begin
		if (m < 0) begin
			sky_phase = sdc_pkg::PHASE_DAY;
		end else if (m >= dawn_on && m < day_on) begin
			sky_phase = sdc_pkg::PHASE_DAWN;
		end else if (m >= day_on && m < dusk_on) begin
			sky_phase = sdc_pkg::PHASE_DAY;
		end else if (m >= dusk_on && m < twi_on) begin
			sky_phase = sdc_pkg::PHASE_DUSK;
		end else if (m >= twi_on && m < night_on) begin
			sky_phase = sdc_pkg::PHASE_TWILIGHT;
		end else begin
			sky_phase = sdc_pkg::PHASE_NIGHT;
		end
	end

	assign summer_active = summer;

endmodule

### src/sun_daypart_classifier_core.sv
// sun_daypart_classifier_core: top level, pipeline control, config registers, table rams
// depends on sdc_pkg, sdc_ram, sdc_calendar, sdc_phase

// Takes one transaction per clock cycle when the output side keeps up. A load
// transaction (action 0) writes the sunrise and sunset tables and gives no result;
// a classify transaction (action 1) gives a registered result: the year quotient
// is registered as it is taken, then the day of year and the table read (one read
// port per table) are registered, then the daylight saving and window compare.
// A load is seen by any classify taken after it, including the very next one.
// A stalled output holds its result while up to two more classifies enter; loads
// pass while no classify waits at the compare. Configuration writes take effect at
// once and must be made by the user while the block is idle; the block never checks.

module sun_daypart_classifier_core #(
	parameter int TABLE_DAYS = 366
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [8:0]                        entry_index,
	input  logic [10:0]                       rise_minute,
	input  logic [10:0]                       fall_minute,
	input  logic [11:0]                       year_number,
	input  logic [3:0]                        month_number,
	input  logic [4:0]                        day_number,
	input  logic signed [11:0]                minute_of_day,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        sky_phase,
	output logic                              summer_active
);

	localparam int AW = $clog2(TABLE_DAYS);

	sdc_pkg::cfg_t cfg_q;
	sdc_pkg::cal_t cal;

	logic               en_o;
	logic               en2;
	logic               en1;
	logic               accept;
	logic [25:0]        q25_prod;

	logic               v_s1;
	logic               act_s1;
	logic [8:0]         idx_s1;
	logic [10:0]        rise_s1;
	logic [10:0]        fall_s1;
	logic [11:0]        yr_s1;
	logic [3:0]         mo_s1;
	logic [4:0]         dy_s1;
	logic signed [11:0] min_s1;
	logic [7:0]         q25_s1;

	logic               v_s2;
	logic [3:0]         mo_s2;
	logic [4:0]         dy_s2;
	logic signed [11:0] min_s2;
	logic [12:0]        wk_sum_s2;
	logic [9:0]         wk_quot_s2;

	logic               ram_we;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [10:0]        rise_rd;
	logic [10:0]        fall_rd;
	logic [2:0]         phase_c;
	logic               summer_c;

	assign en_o     = !out_valid || out_ready;
	assign en2      = !v_s2 || en_o;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && in_ready;

	assign q25_prod = 26'(year_number) * 26'(sdc_pkg::RECIP_25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dawn_lead     <= 8'd10;
			cfg_q.dawn_tail     <= 8'd25;
			cfg_q.dusk_lead     <= 8'd30;
			cfg_q.dusk_tail     <= 8'd10;
			cfg_q.twilight_tail <= 8'd30;
			cfg_q.summer_shift  <= sdc_pkg::MINUTES_PER_HOUR;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sdc_pkg::CFG_DAWN_LEAD:     cfg_q.dawn_lead     <= cfg_data;
				sdc_pkg::CFG_DAWN_TAIL:     cfg_q.dawn_tail     <= cfg_data;
				sdc_pkg::CFG_DUSK_LEAD:     cfg_q.dusk_lead     <= cfg_data;
				sdc_pkg::CFG_DUSK_TAIL:     cfg_q.dusk_tail     <= cfg_data;
				sdc_pkg::CFG_TWILIGHT_TAIL: cfg_q.twilight_tail <= cfg_data;
				sdc_pkg::CFG_SUMMER_SHIFT:  cfg_q.summer_shift  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1 && act_s1;
			end
			if (en_o) begin
				out_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= action;
			idx_s1  <= entry_index;
			rise_s1 <= rise_minute;
			fall_s1 <= fall_minute;
			yr_s1   <= year_number;
			mo_s1   <= month_number;
			dy_s1   <= day_number;
			min_s1  <= minute_of_day;
			q25_s1  <= q25_prod[23:16];
		end
		if (en2) begin
			mo_s2      <= mo_s1;
			dy_s2      <= dy_s1;
			min_s2     <= min_s1;
			wk_sum_s2  <= cal.wk_sum;
			wk_quot_s2 <= cal.wk_quot;
		end
		if (en_o && v_s2) begin
			sky_phase     <= phase_c;
			summer_active <= summer_c;
		end
	end

	sdc_calendar u_calendar (
		.year_number  (yr_s1),
		.month_number (mo_s1),
		.day_number   (dy_s1),
		.year_q25     (q25_s1),
		.cal          (cal)
	);

	assign ram_we = v_s1 && !act_s1 && (32'(idx_s1) < TABLE_DAYS);
	assign waddr  = AW'(idx_s1);
	assign raddr  = (32'(cal.day_idx) < TABLE_DAYS) ? AW'(cal.day_idx) : AW'(TABLE_DAYS - 1);

	sdc_ram #(
		.WIDTH (sdc_pkg::TIME_W),
		.DEPTH (TABLE_DAYS)
	) u_sunrise_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (rise_s1),
		.re    (en2),
		.raddr (raddr),
		.rdata (rise_rd)
	);

	sdc_ram #(
		.WIDTH (sdc_pkg::TIME_W),
		.DEPTH (TABLE_DAYS)
	) u_sunset_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (fall_s1),
		.re    (en2),
		.raddr (raddr),
		.rdata (fall_rd)
	);

	sdc_phase u_phase (
		.cfg           (cfg_q),
		.month_number  (mo_s2),
		.day_number    (dy_s2),
		.minute_of_day (min_s2),
		.wk_sum        (wk_sum_s2),
		.wk_quot       (wk_quot_s2),
		.rise          (rise_rd),
		.fall          (fall_rd),
		.sky_phase     (phase_c),
		.summer_active (summer_c)
	);

endmodule

### tb/sdc_tb_pkg.sv
// sdc_tb_pkg: calendar helpers and action codes shared by the classifier testbench
// no dependencies; used by sdc_daypart_checker and tb_sun_daypart_classifier_core

package sdc_tb_pkg;

	localparam int TABLE_SLOTS = 366;

	localparam logic ACT_LOAD     = 1'b0;
	localparam logic ACT_CLASSIFY = 1'b1;

	function automatic int days_before(input int m);
		int r;
		case (m)
			1:       r = 0;
			2:       r = 31;
			3:       r = 59;
			4:       r = 90;
			5:       r = 120;
			6:       r = 151;
			7:       r = 181;
			8:       r = 212;
			9:       r = 243;
			10:      r = 273;
			11:      r = 304;
			default: r = 334;
		endcase
		return r;
	endfunction

	// table slot for a date: month clamped to 1..12, day 0 taken as day 1
	function automatic logic [8:0] day_slot(input logic [11:0] yr, input logic [3:0] mo,
			input logic [4:0] dy);
		int y, m, d, doy;
		bit leap;
		y = yr;
		m = mo;
		d = dy;
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (d < 1) d = 1;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		doy = days_before(m) + d;
		if (leap && m > 2) doy++;
		if (doy > TABLE_SLOTS) doy = TABLE_SLOTS;
		return 9'(doy - 1);
	endfunction

endpackage

### tb/sdc_daypart_checker.sv
// sdc_daypart_checker: watches the classifier channels, predicts each daypart and compares
// depends on sdc_pkg and sdc_tb_pkg

module sdc_daypart_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [sdc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            action,
	input  logic [8:0]                      entry_index,
	input  logic [10:0]                     rise_minute,
	input  logic [10:0]                     fall_minute,
	input  logic [11:0]                     year_number,
	input  logic [3:0]                      month_number,
	input  logic [4:0]                      day_number,
	input  logic signed [11:0]              minute_of_day,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [2:0]                      sky_phase,
	input  logic                            summer_active,
	output int                              mismatches,
	output int                              pending,
	output int                              checked
);
	import sdc_pkg::*;
	import sdc_tb_pkg::*;

	// month key plus day for march 8 and november 1
	localparam int MAR8_KEY_DAY = 10;
	localparam int NOV1_KEY_DAY = 3;

	typedef struct {
		logic [2:0] sky_phase;
		logic       summer_active;
	} daypart_t;

	daypart_t    daypart_q [$];
	logic [10:0] sunrise_tbl [TABLE_SLOTS];
	logic [10:0] sunset_tbl [TABLE_SLOTS];
	logic [7:0]  dawn_lead, dawn_tail, dusk_lead, dusk_tail, twilight_tail;
	logic [6:0]  summer_shift;
	int          fail_total;
	int          compare_total;

	function automatic int weekday(input int yr, input int key_day);
		return (yr + yr / 4 - yr / 100 + yr / 400 + key_day) % 7;
	endfunction

	function automatic bit dst_applies(input int yr, input int mo, input int dy);
		if (mo < 3 || mo > 11) return 1'b0;
		if (mo > 3 && mo < 11) return 1'b1;
		if (mo == 3) return dy >= 8 + (7 - weekday(yr, MAR8_KEY_DAY)) % 7;
		return dy < 1 + (7 - weekday(yr, NOV1_KEY_DAY)) % 7;
	endfunction

	function automatic daypart_t predict_daypart(input logic [11:0] yr, input logic [3:0] mo,
			input logic [4:0] dy, input logic signed [11:0] mn);
		daypart_t r;
		int slot, minute, shift, rise_at, fall_at;
		r.summer_active = dst_applies(yr, mo, dy);
		minute = mn;
		if (minute < 0) begin
			r.sky_phase = PHASE_DAY;
		end else begin
			slot = day_slot(yr, mo, dy);
			shift = r.summer_active ? int'(summer_shift) : 0;
			rise_at = int'(sunrise_tbl[slot]) + shift;
			fall_at = int'(sunset_tbl[slot]) + shift;
			if (minute >= rise_at - int'(dawn_lead) && minute < rise_at + int'(dawn_tail))
				r.sky_phase = PHASE_DAWN;
			else if (minute >= rise_at + int'(dawn_tail) && minute < fall_at - int'(dusk_lead))
				r.sky_phase = PHASE_DAY;
			else if (minute >= fall_at - int'(dusk_lead) && minute < fall_at + int'(dusk_tail))
				r.sky_phase = PHASE_DUSK;
			else if (minute >= fall_at + int'(dusk_tail) && minute < fall_at + int'(twilight_tail))
				r.sky_phase = PHASE_TWILIGHT;
			else
				r.sky_phase = PHASE_NIGHT;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		daypart_t want;
		if (!arst_n) begin
			daypart_q.delete();
			dawn_lead = 8'd10;
			dawn_tail = 8'd25;
			dusk_lead = 8'd30;
			dusk_tail = 8'd10;
			twilight_tail = 8'd30;
			summer_shift = 7'd60;
			fail_total = 0;
			compare_total = 0;
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_DAWN_LEAD:     dawn_lead = cfg_data;
					CFG_DAWN_TAIL:     dawn_tail = cfg_data;
					CFG_DUSK_LEAD:     dusk_lead = cfg_data;
					CFG_DUSK_TAIL:     dusk_tail = cfg_data;
					CFG_TWILIGHT_TAIL: twilight_tail = cfg_data;
					CFG_SUMMER_SHIFT:  summer_shift = cfg_data[6:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (daypart_q.size() == 0) begin
					$error("sky_phase: no transaction waiting, got %0d (summer_active %0d)",
						sky_phase, summer_active);
					fail_total++;
				end else begin
					want = daypart_q.pop_front();
					compare_total++;
					if (sky_phase !== want.sky_phase) begin
						$error("sky_phase: expected %0d, got %0d", want.sky_phase, sky_phase);
						fail_total++;
					end
					if (summer_active !== want.summer_active) begin
						$error("summer_active: expected %0d, got %0d", want.summer_active,
							summer_active);
						fail_total++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (action == ACT_LOAD) begin
					if (entry_index < TABLE_SLOTS) begin
						sunrise_tbl[entry_index] = rise_minute;
						sunset_tbl[entry_index] = fall_minute;
					end
				end else begin
					daypart_q.push_back(predict_daypart(year_number, month_number, day_number,
						minute_of_day));
				end
			end
			mismatches <= fail_total;
			pending <= daypart_q.size();
			checked <= compare_total;
		end
	end

endmodule

### tb/tb_sun_daypart_classifier_core.sv
// tb_sun_daypart_classifier_core: stimulus, reset, handshake pacing and verdict
// depends on sdc_pkg, sdc_tb_pkg, sdc_daypart_checker and sun_daypart_classifier_core

module tb_sun_daypart_classifier_core;
	import sdc_pkg::*;
	import sdc_tb_pkg::*;

	localparam int          ITEMS_PER_SETTING = 150;
	localparam int          SETTING_COUNT     = 6;
	localparam int          DRAIN_CYCLES      = 8;
	localparam int unsigned CYCLE_LIMIT       = 200000;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {
		SET_ZERO,
		SET_MAX,
		SET_RANDOM
	} setting_kind_t;

	typedef struct {
		logic              action;
		logic [8:0]        entry_index;
		logic [10:0]       rise_minute;
		logic [10:0]       fall_minute;
		logic [11:0]       year_number;
		logic [3:0]        month_number;
		logic [4:0]        day_number;
		logic signed [11:0] minute_of_day;
	} sdc_txn_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   action;
	logic [8:0]             entry_index;
	logic [10:0]            rise_minute;
	logic [10:0]            fall_minute;
	logic [11:0]            year_number;
	logic [3:0]             month_number;
	logic [4:0]             day_number;
	logic signed [11:0]     minute_of_day;
	logic                   out_valid;
	logic                   out_ready;
	logic [2:0]             sky_phase;
	logic                   summer_active;

	int          mismatches;
	int          pending;
	int          checked;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;
	int          loads_sent = 0;
	int          classifies_sent = 0;
	int          settings_done = 0;
	logic [7:0]  shift_now = 8'd60;
	logic [10:0] rise_shadow [TABLE_SLOTS];
	logic [10:0] fall_shadow [TABLE_SLOTS];
	bit          loaded [TABLE_SLOTS];

	always #1 clk = ~clk;

	sun_daypart_classifier_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.entry_index   (entry_index),
		.rise_minute   (rise_minute),
		.fall_minute   (fall_minute),
		.year_number   (year_number),
		.month_number  (month_number),
		.day_number    (day_number),
		.minute_of_day (minute_of_day),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sky_phase     (sky_phase),
		.summer_active (summer_active)
	);

	sdc_daypart_checker daypart_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.entry_index   (entry_index),
		.rise_minute   (rise_minute),
		.fall_minute   (fall_minute),
		.year_number   (year_number),
		.month_number  (month_number),
		.day_number    (day_number),
		.minute_of_day (minute_of_day),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sky_phase     (sky_phase),
		.summer_active (summer_active),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sun_daypart_classifier_core failed");
			$finish;
		end
	end

	// result side: random stall before each result, none while calm
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_txn(input sdc_txn_t t);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= t.action;
		entry_index <= t.entry_index;
		rise_minute <= t.rise_minute;
		fall_minute <= t.fall_minute;
		year_number <= t.year_number;
		month_number <= t.month_number;
		day_number <= t.day_number;
		minute_of_day <= t.minute_of_day;
		do @(posedge clk); while (!in_ready);
		if (t.action == ACT_LOAD) begin
			loads_sent++;
			if (t.entry_index < TABLE_SLOTS) begin
				rise_shadow[t.entry_index] = t.rise_minute;
				fall_shadow[t.entry_index] = t.fall_minute;
				loaded[t.entry_index] = 1'b1;
			end
		end else begin
			classifies_sent++;
		end
	endtask

	task automatic load_entry(input logic [8:0] slot, input logic [10:0] rise,
			input logic [10:0] fall);
		sdc_txn_t t;
		t.action = ACT_LOAD;
		t.entry_index = slot;
		t.rise_minute = rise;
		t.fall_minute = fall;
		t.year_number = 12'($urandom);
		t.month_number = 4'($urandom);
		t.day_number = 5'($urandom);
		t.minute_of_day = 12'($urandom);
		send_txn(t);
	endtask

	// mostly plausible sunrise and sunset, sometimes anything in range
	task automatic fill_entry(input logic [8:0] slot);
		logic [10:0] rise, fall;
		rise = ($urandom_range(0, 9) < 6) ? 11'($urandom_range(240, 600)) :
			11'($urandom_range(0, 1439));
		fall = ($urandom_range(0, 9) < 6) ? 11'($urandom_range(960, 1320)) :
			11'($urandom_range(0, 1439));
		load_entry(slot, rise, fall);
	endtask

	task automatic classify_date(input int yr, input int mo, input int dy, input int mn);
		sdc_txn_t t;
		logic [8:0] slot;
		slot = day_slot(12'(yr), 4'(mo), 5'(dy));
		if (!loaded[slot]) fill_entry(slot);
		t.action = ACT_CLASSIFY;
		t.entry_index = 9'($urandom);
		t.rise_minute = 11'($urandom);
		t.fall_minute = 11'($urandom);
		t.year_number = 12'(yr);
		t.month_number = 4'(mo);
		t.day_number = 5'(dy);
		t.minute_of_day = 12'(mn);
		send_txn(t);
	endtask

	task automatic classify_random();
		int yr, mo, dy, mn, anchor, r;
		logic [8:0] slot;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 5))
				0:       yr = 1900;
				1:       yr = 2000;
				2:       yr = 2100;
				3:       yr = 2024;
				4:       yr = 4095;
				default: yr = 1;
			endcase
		end else begin
			yr = $urandom_range(1, 4095);
		end
		r = $urandom_range(0, 99);
		if (r < 70) mo = $urandom_range(1, 12);
		else if (r < 92) mo = $urandom_range(0, 1) ? MONTH_MAR : MONTH_NOV;
		else if (r < 95) mo = 0;
		else mo = $urandom_range(13, 15);
		if (mo == MONTH_MAR) dy = $urandom_range(1, 16);
		else if (mo == MONTH_NOV) dy = $urandom_range(1, 10);
		else if ($urandom_range(0, 99) < 4) dy = 0;
		else dy = $urandom_range(1, 31);
		slot = day_slot(12'(yr), 4'(mo), 5'(dy));
		if (!loaded[slot] || $urandom_range(0, 9) == 0) fill_entry(slot);
		r = $urandom_range(0, 99);
		if (r < 8) begin
			mn = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 2048)) : -1;
		end else if (r < 50) begin
			mn = $urandom_range(0, 1439);
		end else begin
			// aim near a window edge around sunrise or sunset
			if ($urandom_range(0, 1)) anchor = rise_shadow[slot];
			else anchor = fall_shadow[slot];
			if ($urandom_range(0, 1)) anchor = anchor + int'(shift_now);
			mn = anchor + int'($urandom_range(0, 600)) - 300;
			if (mn < 0) mn = 0;
			if (mn > 1439) mn = 1439;
		end
		classify_date(yr, mo, dy, mn);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic apply_setting(input setting_kind_t kind);
		logic [7:0] v_dawn_lead, v_dawn_tail, v_dusk_lead, v_dusk_tail, v_twilight, v_shift;
		case (kind)
			SET_ZERO: begin
				v_dawn_lead = 8'd0;
				v_dawn_tail = 8'd0;
				v_dusk_lead = 8'd0;
				v_dusk_tail = 8'd0;
				v_twilight = 8'd0;
				v_shift = 8'd0;
			end
			SET_MAX: begin
				v_dawn_lead = 8'd255;
				v_dawn_tail = 8'd255;
				v_dusk_lead = 8'd255;
				v_dusk_tail = 8'd255;
				v_twilight = 8'd255;
				v_shift = 8'd120;
			end
			default: begin
				v_dawn_lead = 8'($urandom_range(0, 255));
				v_dawn_tail = 8'($urandom_range(0, 255));
				v_dusk_lead = 8'($urandom_range(0, 255));
				v_dusk_tail = 8'($urandom_range(0, 255));
				v_twilight = 8'($urandom_range(0, 255));
				v_shift = 8'($urandom_range(0, 120));
			end
		endcase
		if (kind == SET_RANDOM) cfg_write(CFG_SPARE_LO, 8'($urandom));
		cfg_write(CFG_DAWN_LEAD, v_dawn_lead);
		cfg_write(CFG_DAWN_TAIL, v_dawn_tail);
		cfg_write(CFG_DUSK_LEAD, v_dusk_lead);
		cfg_write(CFG_DUSK_TAIL, v_dusk_tail);
		cfg_write(CFG_TWILIGHT_TAIL, v_twilight);
		cfg_write(CFG_SUMMER_SHIFT, v_shift);
		if (kind == SET_RANDOM) cfg_write(CFG_SPARE_HI, 8'($urandom));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shift_now = v_shift;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= ACT_LOAD;
		entry_index <= '0;
		rise_minute <= '0;
		fall_minute <= '0;
		year_number <= '0;
		month_number <= '0;
		day_number <= '0;
		minute_of_day <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table extremes, ignored loads, calendar corners, dst edges
		load_entry(9'd0, 11'd0, 11'd1439);
		load_entry(9'd365, 11'd1439, 11'd0);
		load_entry(9'd511, 11'd1000, 11'd500);
		load_entry(9'd366, 11'd1439, 11'd1439);
		load_entry(9'd59, 11'd400, 11'd1100);
		classify_date(2024, MONTH_JAN, 1, 0);
		classify_date(4095, MONTH_DEC, 31, 1439);
		classify_date(2000, MONTH_DEC, 31, 1439);
		classify_date(1900, MONTH_MAR, 1, 390);
		classify_date(2000, MONTH_FEB, 29, 1080);
		classify_date(0, MONTH_DEC, 31, 700);
		classify_date(2023, 0, 0, 5);
		classify_date(2024, 15, 31, 20);
		classify_date(2023, 13, 1, 1000);
		classify_date(2023, MONTH_FEB, 31, 600);
		classify_date(2024, 7, 4, -1);
		classify_date(2024, 7, 4, -2048);
		classify_date(2024, MONTH_MAR, 9, 400);
		classify_date(2024, MONTH_MAR, 10, 400);
		classify_date(2024, MONTH_NOV, 2, 400);
		classify_date(2024, MONTH_NOV, 3, 400);
		classify_date(2026, MONTH_MAR, 7, 400);
		classify_date(2026, MONTH_MAR, 8, 400);
		classify_date(2026, MONTH_NOV, 1, 400);

		for (int s = 0; s < SETTING_COUNT; s++) begin
			if (s != 0) begin
				wait_idle();
				case (s)
					1:       apply_setting(SET_ZERO);
					2:       apply_setting(SET_MAX);
					default: apply_setting(SET_RANDOM);
				endcase
			end
			settings_done++;
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 99) < 15) begin
					if ($urandom_range(0, 19) == 0)
						fill_entry(9'($urandom_range(TABLE_SLOTS, 511)));
					else
						fill_entry(9'($urandom_range(0, TABLE_SLOTS - 1)));
				end else begin
					classify_random();
				end
			end
		end

		calm = 1'b0;
		wait_idle();
		$display("summary: %0d table loads, %0d classifications, %0d register settings",
			loads_sent, classifies_sent, settings_done);
		$display("summary: %0d results compared, %0d mismatches", checked, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("tb_sun_daypart_classifier_core passed");
		else
			$display("tb_sun_daypart_classifier_core failed");
		$finish;
	end

endmodule

### sun_daypart_classifier_core.f
src/sdc_pkg.sv
src/sdc_ram.sv
src/sdc_calendar.sv
src/sdc_phase.sv
src/sun_daypart_classifier_core.sv
tb/sdc_tb_pkg.sv
tb/sdc_daypart_checker.sv
tb/tb_sun_daypart_classifier_core.sv
